// ===== hdl/sie_pkg.sv =====
// Shared types and constants for the inverted Sobel edge map block.
// No dependencies; imported by every module of the block but sie_ram.
`default_nettype none

package sie_pkg;

   localparam int PIX_W          = 8;
   localparam int RAM_W          = 2 * PIX_W;   // {line_two_back, line_one_back}
   localparam int CSR_ADDR_W     = 1;
   localparam int CSR_DATA_W     = 13;
   localparam int WIDTH_FIELD_W  = 11;
   localparam int HEIGHT_FIELD_W = 13;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;
   localparam int OUT_DEPTH      = 4;
   localparam int OUT_PTR_W      = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

   localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // per-pixel control decided at accept time
   typedef struct packed {
      logic emit;     // pixel completes a result
      logic border;   // that result is on the frame border
      logic last;     // that result is the frame's last pixel
   } tag_type;

   typedef struct packed {
      logic s1_busy;
      logic s2_busy;
   } pipe_status_type;

   typedef struct packed {
      logic             last;
      logic [PIX_W-1:0] edge_val;
   } out_item_type;

endpackage

`default_nettype wire

// ===== hdl/sobel_inverted_edge_map.sv =====
// Top level of the streaming inverted Sobel edge map.
// Depends on sie_pkg, sie_ram, sie_ctrl, sie_window and sie_fifo.
//
//  channel | direction | beat contents                      | handshake
//  --------+-----------+------------------------------------+---------------------
//  req_    | in        | tdata pixel_value, tuser mode      | req_tvalid/req_tready
//  rsp_    | out       | tdata edge_value, tlast frame_end  | rsp_tvalid/rsp_tready
//  csr_    | in        | addr register index, wdata value   | csr_valid/csr_ready
//
// Throughput: one pixel per clock; the line store is one dual-port RAM that is
//   read at accept and written back in the next cycle, same-address hits forwarded.
// Path: the pixel completing a result passes stage 1, stage 2 and the result
//   queue before its beat shows on rsp_tvalid.
// Stalls: req_tready drops only when the 4-entry result queue plus in-flight
//   pixels could fill it; csr_ready is always high.
// Reset: counters and geometry reset at once; the line stores are not cleared.
`default_nettype none

module sobel_inverted_edge_map #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sie_pkg::PIX_W-1:0]         req_tdata,   // [7:0] pixel_value
   input  wire logic                              req_tuser,   // [0] mode (1 = flush)
   // rsp
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sie_pkg::PIX_W-1:0]              rsp_tdata,   // [7:0] edge_value
   output logic                                   rsp_tlast,   // frame_end
   // csr
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sie_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [sie_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sie_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic                  req_fire;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   tag_type               tag;
   logic [PIX_W-1:0]      pixel;

   logic                  ram_wen;
   logic [AW-1:0]         ram_waddr;
   logic [RAM_W-1:0]      ram_wdata, ram_rdata;

   logic                  push_valid;
   out_item_type          push_item, head_item;
   pipe_status_type       status;
   logic [OUT_CNT_W-1:0]  fifo_count;
   logic [OUT_CNT_W-1:0]  occupancy;

   // queue slots already spoken for: queued results plus pixels in the pipe
   assign occupancy  = fifo_count + OUT_CNT_W'(status.s1_busy) + OUT_CNT_W'(status.s2_busy);
   assign req_tready = occupancy < OUT_CNT_W'(OUT_DEPTH);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // a flush pushes a zero pixel
   assign pixel = req_tuser ? '0 : req_tdata;

   sie_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_fire  (req_fire),
      .req_flush (req_tuser),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .tag       (tag)
   );

   // {line_two_back, line_one_back} at one address per column
   sie_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .ren   (rd_en),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   sie_window #(
      .AW (AW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .pixel      (pixel),
      .tag        (tag),
      .ram_rdata  (ram_rdata),
      .ram_wen    (ram_wen),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .status     (status)
   );

   sie_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_item  (push_item),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .count      (fifo_count)
   );

   assign rsp_tdata = head_item.edge_val;
   assign rsp_tlast = head_item.last;

   // credit scheme never lets the result queue overrun
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue credit exceeded");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> fifo_count < OUT_CNT_W'(OUT_DEPTH) || rsp_tready)
      else $error("result pushed into full queue");

   // a result in the Sobel stage came from a pixel in the line-store stage
   a_s2_origin: assert property (@(posedge clock) disable iff (reset)
      status.s2_busy |-> $past(status.s1_busy))
      else $error("Sobel stage valid without a preceding pixel");

endmodule

`default_nettype wire

// ===== hdl/sie_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module sie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wen,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     ren,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rdata <= mem[raddr];   // old data on same-address write
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sie_ctrl.sv =====
// Frame geometry registers and raster counters; decides per accepted pixel
// whether it emits, where it reads the line store, border and frame end. Uses sie_pkg.
`default_nettype none

module sie_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [sie_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [sie_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_fire,
   input  wire logic                              req_flush,
   output logic                                   rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
   output sie_pkg::tag_type                       tag
);
   import sie_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int FW = $clog2(MAX_WIDTH + 2);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;
   localparam int H_RST = (HEIGHT_RESET < MAX_HEIGHT) ? HEIGHT_RESET : MAX_HEIGHT;

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] ocol_ff, ocol_in;
   logic [RW-1:0] orow_ff, orow_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic [WIDTH_FIELD_W-1:0]  w_raw;
   logic [HEIGHT_FIELD_W-1:0] h_raw;
   logic [WW-1:0] w_clamp;
   logic [HW-1:0] h_clamp;
   logic          drop, emit, border, last, col_wrap, ocol_wrap, orow_wrap;

   assign w_raw = csr_wdata[WIDTH_FIELD_W-1:0];
   assign h_raw = csr_wdata[HEIGHT_FIELD_W-1:0];

   always_comb begin
      if (w_raw == '0) begin
         w_clamp = WW'(1);
      end else if (int'(w_raw) > MAX_WIDTH) begin
         w_clamp = WW'(MAX_WIDTH);
      end else begin
         w_clamp = WW'(w_raw);
      end
      if (h_raw == '0) begin
         h_clamp = HW'(1);
      end else if (int'(h_raw) > MAX_HEIGHT) begin
         h_clamp = HW'(MAX_HEIGHT);
      end else begin
         h_clamp = HW'(h_raw);
      end
   end

   // flush on an empty pipeline is a no-op
   assign drop      = req_flush && (fill_ff == '0);
   assign emit      = fill_ff >= (FW'(width_ff) + FW'(1));
   assign ocol_wrap = (WW'(ocol_ff) + WW'(1)) >= width_ff;
   assign orow_wrap = (HW'(orow_ff) + HW'(1)) >= height_ff;
   assign col_wrap  = (WW'(col_ff) + WW'(1)) >= width_ff;
   assign border    = (orow_ff == '0) || (HW'(orow_ff) == height_ff - HW'(1)) ||
                      (ocol_ff == '0) || (WW'(ocol_ff) == width_ff - WW'(1));
   assign last      = emit && (WW'(ocol_ff) == width_ff - WW'(1)) &&
                      (HW'(orow_ff) == height_ff - HW'(1));

   assign rd_en      = req_fire && !drop;
   assign rd_addr    = col_ff;
   assign tag.emit   = emit;
   assign tag.border = border;
   assign tag.last   = last;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      fill_in   = fill_ff;
      if (csr_valid) begin
         case (csr_addr)
            REG_IMAGE_WIDTH: begin
               width_in = w_clamp;
               col_in   = '0;
               ocol_in  = '0;
               orow_in  = '0;
               fill_in  = '0;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = h_clamp;
               col_in    = '0;
               ocol_in   = '0;
               orow_in   = '0;
               fill_in   = '0;
            end
            default: begin
            end
         endcase
      end else if (rd_en) begin
         if (emit) begin
            if (ocol_wrap) begin
               ocol_in = '0;
               orow_in = orow_wrap ? '0 : orow_ff + RW'(1);
            end else begin
               ocol_in = ocol_ff + AW'(1);
            end
         end else begin
            fill_in = fill_ff + FW'(1);
         end
         col_in = col_wrap ? '0 : col_ff + AW'(1);
         if (last) begin
            col_in  = '0;
            ocol_in = '0;
            orow_in = '0;
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(W_RST);
         height_ff <= HW'(H_RST);
         col_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         fill_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sie_window.sv =====
// Line-store read-modify-write with same-address forwarding, 3x3 window and
// the Sobel magnitude stage. Uses sie_pkg; drives the line-store RAM write port.
`default_nettype none

module sie_window #(
   parameter int AW = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [AW-1:0]                rd_addr,
   input  wire logic [sie_pkg::PIX_W-1:0]    pixel,
   input  wire sie_pkg::tag_type             tag,
   input  wire logic [sie_pkg::RAM_W-1:0]    ram_rdata,
   output logic                              ram_wen,
   output logic [AW-1:0]                     ram_waddr,
   output logic [sie_pkg::RAM_W-1:0]         ram_wdata,
   output logic                              push_valid,
   output sie_pkg::out_item_type             push_item,
   output sie_pkg::pipe_status_type          status
);
   import sie_pkg::*;

   // stage 1: line-store data returns
   logic              s1_valid_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [PIX_W-1:0]  s1_pixel_ff;
   tag_type           s1_tag_ff;
   logic              fwd_ff, fwd_in;
   logic [RAM_W-1:0]  fwd_data_ff;
   logic [RAM_W-1:0]  word;
   logic [PIX_W-1:0]  top, mid;

   // window: column 0 newest; each column is {top, mid, bottom}
   logic [2:0][2:0][PIX_W-1:0] win_ff;

   // stage 2: Sobel on the window
   logic              s2_valid_ff;
   logic              s2_border_ff, s2_last_ff;
   logic [9:0]        sum_a, sum_b, sum_c, sum_d;
   logic signed [11:0] gh, gv;
   logic [10:0]       abs_h, abs_v, mag;
   logic [PIX_W-1:0]  mag_sat;

   assign fwd_in = rd_en && s1_valid_ff && (s1_addr_ff == rd_addr);
   assign word   = fwd_ff ? fwd_data_ff : ram_rdata;
   assign top    = word[RAM_W-1:PIX_W];
   assign mid    = word[PIX_W-1:0];

   assign ram_wen   = s1_valid_ff;
   assign ram_waddr = s1_addr_ff;
   assign ram_wdata = {mid, s1_pixel_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         fwd_ff      <= fwd_in;
         s2_valid_ff <= s1_valid_ff && s1_tag_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_addr_ff  <= rd_addr;
         s1_pixel_ff <= pixel;
         s1_tag_ff   <= tag;
      end
      fwd_data_ff <= ram_wdata;
      if (s1_valid_ff) begin
         win_ff[2] <= win_ff[1];
         win_ff[1] <= win_ff[0];
         win_ff[0] <= {top, mid, s1_pixel_ff};
         s2_border_ff <= s1_tag_ff.border;
         s2_last_ff   <= s1_tag_ff.last;
      end
   end

   // gh: newest column minus oldest; gv: bottom row minus top row
   assign sum_a = 10'(win_ff[0][2]) + {1'b0, win_ff[0][1], 1'b0} + 10'(win_ff[0][0]);
   assign sum_b = 10'(win_ff[2][2]) + {1'b0, win_ff[2][1], 1'b0} + 10'(win_ff[2][0]);
   assign sum_c = 10'(win_ff[2][0]) + {1'b0, win_ff[1][0], 1'b0} + 10'(win_ff[0][0]);
   assign sum_d = 10'(win_ff[2][2]) + {1'b0, win_ff[1][2], 1'b0} + 10'(win_ff[0][2]);
   assign gh    = signed'({2'b00, sum_a}) - signed'({2'b00, sum_b});
   assign gv    = signed'({2'b00, sum_c}) - signed'({2'b00, sum_d});
   assign abs_h = gh[11] ? 11'(-gh) : 11'(gh);
   assign abs_v = gv[11] ? 11'(-gv) : 11'(gv);
   assign mag   = abs_h + abs_v;
   assign mag_sat = (mag > 11'(EDGE_MAX)) ? EDGE_MAX : mag[PIX_W-1:0];

   assign push_valid         = s2_valid_ff;
   assign push_item.last     = s2_last_ff;
   assign push_item.edge_val = s2_border_ff ? EDGE_MAX : EDGE_MAX - mag_sat;

   assign status.s1_busy = s1_valid_ff;
   assign status.s2_busy = s2_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/sie_fifo.sv =====
// Small result queue that decouples the Sobel pipeline from rsp back-pressure.
// Uses sie_pkg.
`default_nettype none

module sie_fifo (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire sie_pkg::out_item_type          push_item,
   input  wire logic                           pop,
   output logic                                head_valid,
   output sie_pkg::out_item_type               head_item,
   output logic [sie_pkg::OUT_CNT_W-1:0]       count
);
   import sie_pkg::*;

   out_item_type           mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic                   pop_ok;

   assign pop_ok     = pop && (count_ff != '0);
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop_ok) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (!push && pop_ok) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire
